>>> src/motor_speed_ramp_pwm_top_defines.svh
// ----------------------------------------------------------------------------
// motor speed ramp assertion macros
// shared concurrent assertion forms, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MOTOR_SPEED_RAMP_PWM_TOP_DEFINES_SVH
`define MOTOR_SPEED_RAMP_PWM_TOP_DEFINES_SVH

// consequent in the same cycle
`define MSRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the following cycle
`define MSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/msrp_pkg.sv
// ----------------------------------------------------------------------------
// msrp_pkg
// shared types and constants of the motor speed ramp and drive mapping block
// ----------------------------------------------------------------------------
package msrp_pkg;

  localparam int SPEED_BITS = 7;
  localparam int RAMP_BITS  = 16;
  localparam int LOAD_BITS  = 10;
  localparam int DRIVE_BITS = 11;
  localparam int REM_BITS   = 8;
  localparam int QUO_BITS   = 7;
  localparam int PROD_BITS  = RAMP_BITS + QUO_BITS;

  localparam logic [SPEED_BITS-1:0] SPEED_MAX     = 7'd100;
  localparam logic [SPEED_BITS-1:0] SPEED_SAT     = 7'd127;
  localparam logic [DRIVE_BITS-1:0] ESC_BASE      = 11'd1000;
  localparam logic [7:0]            DUTY_MAX      = 8'd255;
  // 255 * 5243, with 5243 / 2^19 standing in for 1 / 100
  localparam logic [20:0]           DUTY_RECIP    = 21'd1336965;
  localparam int                    DUTY_SHIFT    = 19;
  localparam logic [DRIVE_BITS-1:0] LAST_DRIVE_RST = 11'd0;

  // configuration register indexes
  localparam logic CFG_MOTOR_TYPE = 1'b0;
  localparam logic CFG_OVERLOAD   = 1'b1;

  // motor types
  localparam logic [1:0] MT_ESC     = 2'd0;
  localparam logic [1:0] MT_PWM     = 2'd1;
  localparam logic [1:0] MT_INV_PWM = 2'd2;

  localparam logic [1:0]           MOTOR_TYPE_RST = MT_PWM;
  localparam logic [LOAD_BITS-1:0] OVERLOAD_RST   = 10'd1023;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_MUL,
    ST_DIV,
    ST_MAP,
    ST_DRIVE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load_in;
    logic time_en;
    logic mul_en;
    logic div_en;
    logic map_en;
    logic drive_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_write;
    logic fast;
    logic div_last;
  } sts_t;

endpackage

>>> src/msrp_datapath.sv
// ----------------------------------------------------------------------------
// msrp_datapath
// ramp state, elapsed time, multiply, shift-subtract divide, drive mapping
// ----------------------------------------------------------------------------
module msrp_datapath import msrp_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [SPEED_BITS-1:0]  target_speed_i,
  input  logic [RAMP_BITS-1:0]   ramp_time_i,
  input  logic [TIME_BITS-1:0]   now_ms_i,
  input  logic [LOAD_BITS-1:0]   load_sample_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [LOAD_BITS-1:0]   cfg_data_i,
  output logic [DRIVE_BITS-1:0]  drive_value_o,
  output logic                   drive_written_o,
  output logic [SPEED_BITS-1:0]  applied_speed_o,
  output logic signed [REM_BITS-1:0] remaining_o,
  output logic                   overloaded_o
);

  // configuration
  logic [1:0]           motor_type_q;
  logic [LOAD_BITS-1:0] ovl_level_q;

  // architectural ramp state
  logic [SPEED_BITS-1:0] latched_q, sv_q, cur_q;
  logic [TIME_BITS-1:0]  st_q;
  logic [DRIVE_BITS-1:0] last_drive_q;

  // request registers
  logic [SPEED_BITS-1:0] tgt_q;
  logic [RAMP_BITS-1:0]  ramp_q;
  logic [TIME_BITS-1:0]  now_q;
  logic                  ovl_q;

  // working registers
  logic [RAMP_BITS-1:0]       dt_q;
  logic signed [REM_BITS-1:0] span_q;
  logic                       fast_q, need_q, neg_q;
  logic [PROD_BITS-1:0]       r_q, dv_q;
  logic [QUO_BITS-1:0]        quo_q;
  logic [2:0]                 cnt_q;
  logic [SPEED_BITS-1:0]      nv_q;
  logic signed [REM_BITS-1:0] rem_q;

  // time step
  logic                 gt, past;
  logic [TIME_BITS-1:0] diff;
  logic [RAMP_BITS-1:0] dt_d;
  logic signed [REM_BITS-1:0] span_d;
  logic                 fast_d, need_d;

  // multiply step
  logic [SPEED_BITS-1:0] mag;
  logic [PROD_BITS-1:0]  prod;

  // divide step
  logic                 ge;

  // map step
  logic signed [SPEED_BITS+1:0] qs, v;
  logic [SPEED_BITS-1:0]        nv_d;

  // drive step
  logic [SPEED_BITS-1:0] applied;
  logic [DRIVE_BITS-1:0] esc;
  logic [27:0]           duty_prod;
  logic [7:0]            duty;
  logic [DRIVE_BITS-1:0] drive_d;

  always_comb begin
    gt     = now_q > st_q;
    diff   = now_q - st_q;
    past   = gt && (diff > TIME_BITS'(ramp_q));
    dt_d   = (gt && !past) ? diff[RAMP_BITS-1:0] : '0;
    span_d = $signed({1'b0, tgt_q}) - $signed({1'b0, sv_q});
    fast_d = (ramp_q == '0) || past;
    need_d = tgt_q != cur_q;
  end

  always_comb begin
    mag  = span_q[REM_BITS-1] ? SPEED_BITS'(-span_q) : span_q[SPEED_BITS-1:0];
    prod = PROD_BITS'(dt_q) * PROD_BITS'(mag);
  end

  assign ge = r_q >= dv_q;

  always_comb begin
    qs = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
    v  = $signed({2'b00, sv_q}) + qs;
    if (fast_q) begin
      nv_d = tgt_q;
    end else if (v < 0) begin
      nv_d = '0;
    end else if (v > $signed({2'b00, SPEED_SAT})) begin
      nv_d = SPEED_SAT;
    end else begin
      nv_d = v[SPEED_BITS-1:0];
    end
  end

  always_comb begin
    applied   = (nv_q > SPEED_MAX) ? SPEED_MAX : nv_q;
    esc       = ESC_BASE + DRIVE_BITS'(applied) * DRIVE_BITS'(10);
    duty_prod = 28'(applied) * 28'(DUTY_RECIP);
    duty      = duty_prod[DUTY_SHIFT+7:DUTY_SHIFT];
    case (motor_type_q)
      MT_ESC:     drive_d = esc;
      MT_INV_PWM: drive_d = DRIVE_BITS'(DUTY_MAX - duty);
      default:    drive_d = DRIVE_BITS'(duty);
    endcase
  end

  assign sts_o.need_write = need_d;
  assign sts_o.fast       = fast_d;
  assign sts_o.div_last   = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_type_q <= MOTOR_TYPE_RST;
      ovl_level_q  <= OVERLOAD_RST;
      latched_q    <= '0;
      sv_q         <= '0;
      st_q         <= '0;
      cur_q        <= '0;
      last_drive_q <= LAST_DRIVE_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MOTOR_TYPE: motor_type_q <= cfg_data_i[1:0];
          CFG_OVERLOAD:   ovl_level_q  <= cfg_data_i;
          default:        ;
        endcase
      end
      if (cmd_i.load_in && (target_speed_i != latched_q)) begin
        latched_q <= target_speed_i;
        sv_q      <= cur_q;
        st_q      <= now_ms_i;
      end
      if (cmd_i.drive_en) begin
        last_drive_q <= drive_d;
        cur_q        <= nv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      tgt_q  <= target_speed_i;
      ramp_q <= ramp_time_i;
      now_q  <= now_ms_i;
      ovl_q  <= load_sample_i > ovl_level_q;
    end
    if (cmd_i.time_en) begin
      dt_q   <= dt_d;
      span_q <= span_d;
      fast_q <= fast_d;
      need_q <= need_d;
    end
    if (cmd_i.mul_en) begin
      r_q   <= prod;
      dv_q  <= PROD_BITS'(ramp_q) << (QUO_BITS - 1);
      neg_q <= span_q[REM_BITS-1];
      quo_q <= '0;
      cnt_q <= 3'(QUO_BITS - 1);
    end
    if (cmd_i.div_en) begin
      if (ge) begin
        r_q <= r_q - dv_q;
      end
      quo_q <= {quo_q[QUO_BITS-2:0], ge};
      dv_q  <= dv_q >> 1;
      cnt_q <= cnt_q - 3'd1;
    end
    if (cmd_i.map_en) begin
      nv_q <= nv_d;
    end
    if (cmd_i.drive_en) begin
      rem_q <= $signed({1'b0, tgt_q}) - $signed({1'b0, nv_q});
    end
    if (cmd_i.out_load) begin
      drive_value_o   <= last_drive_q;
      drive_written_o <= need_q;
      applied_speed_o <= (cur_q > SPEED_MAX) ? SPEED_MAX : cur_q;
      remaining_o     <= need_q ? rem_q : '0;
      overloaded_o    <= ovl_q;
    end
  end

endmodule

>>> src/msrp_ctrl.sv
// ----------------------------------------------------------------------------
// msrp_ctrl
// sequencer for one request and output valid register
// ----------------------------------------------------------------------------
`include "motor_speed_ramp_pwm_top_defines.svh"

module msrp_ctrl import msrp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_TIME;
      end
      ST_TIME: begin
        if (!sts_i.need_write) begin
          state_d = ST_OUT;
        end else if (sts_i.fast) begin
          state_d = ST_MAP;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:   state_d = ST_DIV;
      ST_DIV: begin
        if (sts_i.div_last) state_d = ST_MAP;
      end
      ST_MAP:   state_d = ST_DRIVE;
      ST_DRIVE: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = accept;
    cmd_o.time_en  = (state_q == ST_TIME);
    cmd_o.mul_en   = (state_q == ST_MUL);
    cmd_o.div_en   = (state_q == ST_DIV);
    cmd_o.map_en   = (state_q == ST_MAP);
    cmd_o.drive_en = (state_q == ST_DRIVE);
    cmd_o.out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
    out_valid_d    = cmd_o.out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MSRP_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_TIME, "accept did not start work")
  `MSRP_ASSERT_NEXT(a_div_holds, (state_q == ST_DIV) && !sts_i.div_last, state_q == ST_DIV,
                    "divide left early")
  `MSRP_ASSERT_NEXT(a_out_loaded, cmd_o.out_load, out_valid_q && (state_q == ST_IDLE),
                    "result not presented")
  `MSRP_ASSERT_NOW(a_no_overwrite, cmd_o.out_load, !out_valid_q || !out_stall_i,
                   "pending result overwritten")

endmodule

>>> src/motor_speed_ramp_pwm_top.sv
// ----------------------------------------------------------------------------
// motor_speed_ramp_pwm_top
// linear speed ramp with esc pulse or pwm duty mapping and overload flag
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   target_speed, ramp_time, now_ms,
//                                               load_sample
//   out      output     out_valid_o/out_stall_i drive_value, drive_written,
//                                               applied_speed, remaining, overloaded
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// one request at a time: when already at target the time step goes straight to
// the result register; when the ramp is done or has zero length it adds map and
// drive; ramping adds multiply and shift-subtract divide before the result is loaded
// asynchronous active-low reset; no clearing pass
// a new request is taken while a finished result waits on out_stall_i
// ----------------------------------------------------------------------------
module motor_speed_ramp_pwm_top import msrp_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [SPEED_BITS-1:0]      target_speed_i,
  input  logic [RAMP_BITS-1:0]       ramp_time_i,
  input  logic [TIME_BITS-1:0]       now_ms_i,
  input  logic [LOAD_BITS-1:0]       load_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [DRIVE_BITS-1:0]      drive_value_o,
  output logic                       drive_written_o,
  output logic [SPEED_BITS-1:0]      applied_speed_o,
  output logic signed [REM_BITS-1:0] remaining_o,
  output logic                       overloaded_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [LOAD_BITS-1:0]       cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  msrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  msrp_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .target_speed_i  (target_speed_i),
    .ramp_time_i     (ramp_time_i),
    .now_ms_i        (now_ms_i),
    .load_sample_i   (load_sample_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .drive_value_o   (drive_value_o),
    .drive_written_o (drive_written_o),
    .applied_speed_o (applied_speed_o),
    .remaining_o     (remaining_o),
    .overloaded_o    (overloaded_o)
  );

endmodule
